@@ sv/lppd_pkg.sv @@
// Shared types, codes and constants for the length-prefixed packet deframer.
package lppd_pkg;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned IndexW = 16;
  localparam int unsigned RoleW  = 2;
  localparam int unsigned StatW  = 2;

  // APB geometry: 32-bit data bus, two registers at byte addresses 0 and 4
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  // Register reset values
  localparam logic [ByteW-1:0] ShortTypeRst = 8'hC1;
  localparam logic [ByteW-1:0] LongTypeRst  = 8'hC2;

  // Header sizes (type + length byte(s) + head code)
  localparam logic [IndexW-1:0] ShortHdrLen = 16'd3;
  localparam logic [IndexW-1:0] LongHdrLen  = 16'd4;

  // Register indexes
  typedef enum logic [0:0] {
    REG_SHORT_TYPE = 1'b0,
    REG_LONG_TYPE  = 1'b1
  } reg_idx_e;

  // Frame position, one-hot
  typedef enum logic [4:0] {
    PH_TYPE = 5'b00001,
    PH_LEN1 = 5'b00010,
    PH_LEN2 = 5'b00100,
    PH_HEAD = 5'b01000,
    PH_BODY = 5'b10000
  } phase_e;

  // Role of a byte within its frame
  typedef enum logic [RoleW-1:0] {
    ROLE_TYPE = 2'd0,
    ROLE_LEN  = 2'd1,
    ROLE_HEAD = 2'd2,
    ROLE_BODY = 2'd3
  } role_e;

  // Per-item status
  typedef enum logic [StatW-1:0] {
    ST_FRAME   = 2'd0,
    ST_DISCARD = 2'd1,
    ST_BADTYPE = 2'd2,
    ST_BADLEN  = 2'd3
  } status_e;

  // Type codes from the register block
  typedef struct packed {
    logic [ByteW-1:0] short_type_code;
    logic [ByteW-1:0] long_type_code;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [ByteW-1:0]  data_byte;
    role_e             byte_role;
    logic [IndexW-1:0] frame_index;
    logic [ByteW-1:0]  frame_head_code;
    logic [IndexW-1:0] frame_total;
    logic              frame_first;
    logic              frame_last;
    status_e           status;
  } result_t;

endpackage

@@ sv/length_prefixed_packet_deframer_top.sv @@
// Top level of the length-prefixed packet deframer: stream pipeline and config port.
//
//  Channel   | Dir | Handshake              | Payload
//  s_axis    | in  | tvalid / tready        | tdata: rx_byte; tlast: datagram_last
//  m_axis    | out | tvalid / tready        | tdata/tuser/tlast: decoded byte
//  apb       | in  | psel, penable, pready  | paddr, pwdata, prdata: type codes
//
// One item per cycle while m_axis is ready; each item passes the input register,
// then the result register, the state update being a single 16-bit add and compare.
// Reset clears the pipeline valids and the frame state, and returns the type
// codes to 0xC1 (short) and 0xC2 (long).
// A stall on m_axis holds the result register; the input register still takes
// an item, and s_axis_tready drops only when both registers are full.
module length_prefixed_packet_deframer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
  input  logic                           s_axis_tlast,  // datagram_last
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] data_byte, [23:8] frame_index, [31:24] frame_head_code,
  // [47:32] frame_total
  output logic [47:0]                    m_axis_tdata,
  // [1:0] byte_role, [2] frame_first, [4:3] status
  output logic [4:0]                     m_axis_tuser,
  output logic                           m_axis_tlast,  // frame_last
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lppd_pkg::ApbAddrW-1:0]  paddr,
  input  logic [lppd_pkg::ApbDataW-1:0]  pwdata,
  output logic [lppd_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);

  lppd_pkg::cfg_t             cfg;
  lppd_pkg::result_t          res;
  lppd_pkg::result_t          out_q;
  logic                       out_vld_q;
  logic                       in_vld_q;
  logic [lppd_pkg::ByteW-1:0] in_byte_q;
  logic                       in_last_q;
  logic                       advance;
  logic                       in_take;

  // input register moves on when the result register is free or draining
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  lppd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lppd_step u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .byte_i  (in_byte_q),
    .dlast_i (in_last_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  // input register: valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  // input register: payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // result register: valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  // result register: payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.frame_total, out_q.frame_head_code,
                          out_q.frame_index, out_q.data_byte};
  assign m_axis_tuser  = {out_q.status, out_q.frame_first, out_q.byte_role};
  assign m_axis_tlast  = out_q.frame_last;

endmodule

@@ sv/lppd_cfg.sv @@
// APB register block holding the two frame type codes.
module lppd_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lppd_pkg::ApbAddrW-1:0]      paddr,
  input  logic [lppd_pkg::ApbDataW-1:0]      pwdata,
  output logic [lppd_pkg::ApbDataW-1:0]      prdata,
  output logic                               pready,
  output lppd_pkg::cfg_t                     cfg_o
);

  logic [lppd_pkg::ByteW-1:0] short_q, short_d;
  logic [lppd_pkg::ByteW-1:0] long_q, long_d;
  logic                       wr_en;
  lppd_pkg::reg_idx_e         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  // word address: bit 2 selects the register, low bits ignored
  assign reg_idx = lppd_pkg::reg_idx_e'(paddr[2]);

  // write decode
  always_comb begin
    short_d = short_q;
    long_d  = long_q;
    if (wr_en) begin
      case (reg_idx)
        lppd_pkg::REG_SHORT_TYPE: short_d = pwdata[lppd_pkg::ByteW-1:0];
        lppd_pkg::REG_LONG_TYPE:  long_d  = pwdata[lppd_pkg::ByteW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= lppd_pkg::ShortTypeRst;
      long_q  <= lppd_pkg::LongTypeRst;
    end else begin
      short_q <= short_d;
      long_q  <= long_d;
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    case (reg_idx)
      lppd_pkg::REG_SHORT_TYPE: prdata[lppd_pkg::ByteW-1:0] = short_q;
      lppd_pkg::REG_LONG_TYPE:  prdata[lppd_pkg::ByteW-1:0] = long_q;
      default: ;
    endcase
  end

  assign cfg_o.short_type_code = short_q;
  assign cfg_o.long_type_code  = long_q;

endmodule

@@ sv/lppd_step.sv @@
// Frame tracking state and the per-byte decode logic.
module lppd_step (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic [lppd_pkg::ByteW-1:0]    byte_i,
  input  logic                          dlast_i,
  input  lppd_pkg::cfg_t                cfg_i,
  output lppd_pkg::result_t             res_o
);

  lppd_pkg::phase_e              phase_q, phase_d;
  logic                          long_q, long_d;
  logic [lppd_pkg::IndexW-1:0]   total_q, total_d;
  logic [lppd_pkg::IndexW-1:0]   cnt_q, cnt_d;
  logic [lppd_pkg::ByteW-1:0]    head_q, head_d;
  logic                          drop_q, drop_d;

  logic [lppd_pkg::IndexW-1:0]   cnt_inc;
  logic [lppd_pkg::IndexW-1:0]   total_new;
  logic [lppd_pkg::IndexW-1:0]   hdr_len;
  logic                          len_done;

  assign cnt_inc = cnt_q + 16'd1;
  assign hdr_len = long_q ? lppd_pkg::LongHdrLen : lppd_pkg::ShortHdrLen;

  // next state and result for the byte at the input
  always_comb begin
    phase_d   = phase_q;
    long_d    = long_q;
    total_d   = total_q;
    cnt_d     = cnt_q;
    head_d    = head_q;
    drop_d    = drop_q;
    total_new = total_q;
    len_done  = 1'b0;
    res_o           = '0;
    res_o.data_byte = byte_i;

    if (drop_q) begin
      // discarding up to the end of the datagram
      res_o.status = lppd_pkg::ST_DISCARD;
      if (dlast_i) drop_d = 1'b0;
    end else begin
      case (phase_q)
        lppd_pkg::PH_LEN1: begin
          res_o.byte_role   = lppd_pkg::ROLE_LEN;
          res_o.frame_index = cnt_q;
          if (long_q) begin
            total_d = {byte_i, 8'h00};
            cnt_d   = cnt_inc;
            phase_d = lppd_pkg::PH_LEN2;
          end else begin
            total_new = {8'h00, byte_i};
            len_done  = 1'b1;
          end
        end
        lppd_pkg::PH_LEN2: begin
          res_o.byte_role   = lppd_pkg::ROLE_LEN;
          res_o.frame_index = cnt_q;
          total_new         = total_q | {8'h00, byte_i};
          len_done          = 1'b1;
        end
        lppd_pkg::PH_HEAD, lppd_pkg::PH_BODY: begin
          if (phase_q == lppd_pkg::PH_HEAD) begin
            res_o.byte_role       = lppd_pkg::ROLE_HEAD;
            head_d                = byte_i;
            res_o.frame_head_code = byte_i;
          end else begin
            res_o.byte_role       = lppd_pkg::ROLE_BODY;
            res_o.frame_head_code = head_q;
          end
          res_o.frame_index = cnt_q;
          res_o.frame_total = total_q;
          cnt_d             = cnt_inc;
          if (cnt_inc >= total_q) begin
            res_o.frame_last = 1'b1;
            phase_d          = lppd_pkg::PH_TYPE;
          end else begin
            phase_d = lppd_pkg::PH_BODY;
          end
        end
        default: begin
          // type byte; short code wins when both codes match
          head_d  = '0;
          total_d = '0;
          if (byte_i == cfg_i.short_type_code || byte_i == cfg_i.long_type_code) begin
            long_d            = (byte_i != cfg_i.short_type_code);
            res_o.frame_first = 1'b1;
            cnt_d             = 16'd1;
            phase_d           = lppd_pkg::PH_LEN1;
          end else begin
            res_o.status = lppd_pkg::ST_BADTYPE;
            cnt_d        = '0;
            phase_d      = lppd_pkg::PH_TYPE;
            drop_d       = !dlast_i;
          end
        end
      endcase

      // length complete: check it covers the header
      if (len_done) begin
        total_d           = total_new;
        res_o.frame_total = total_new;
        if (total_new < hdr_len) begin
          res_o.status = lppd_pkg::ST_BADLEN;
          cnt_d        = '0;
          phase_d      = lppd_pkg::PH_TYPE;
          drop_d       = !dlast_i;
        end else begin
          cnt_d   = cnt_inc;
          phase_d = lppd_pkg::PH_HEAD;
        end
      end
    end
  end

  // state update on each decoded item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lppd_pkg::PH_TYPE;
      long_q  <= 1'b0;
      total_q <= '0;
      cnt_q   <= '0;
      head_q  <= '0;
      drop_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      long_q  <= long_d;
      total_q <= total_d;
      cnt_q   <= cnt_d;
      head_q  <= head_d;
      drop_q  <= drop_d;
    end
  end

endmodule
